// File: rtl/winner_tree_kway_merge_assert.svh
// Assertion macros used by the winner tree merge top level.
`ifndef WINNER_TREE_KWAY_MERGE_ASSERT_SVH
`define WINNER_TREE_KWAY_MERGE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define WTKM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("winner tree merge check failed");

// Next-cycle implication, disabled while reset is held.
`define WTKM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("winner tree merge check failed");

`endif

// File: rtl/wtkm_pkg.sv
// Package with the shared types and constants of the winner tree merge.
`default_nettype none
package wtkm_pkg;

    localparam int KIND_W   = 2;
    localparam int STREAM_W = 6;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD    = 2'd0,
        KIND_START   = 2'd1,
        KIND_ADVANCE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_VAL_A,
        ST_VAL_B,
        ST_CMP,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic adv_upd;
        logic bld_init;
        logic rd_a;
        logic rd_b;
        logic val_a;
        logic val_b;
        logic cmp;
        logic step_up;
        logic emit_rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic root_ok;
        logic node_root;
    } t_stat;

endpackage
`default_nettype wire

// File: rtl/wtkm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wtkm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/wtkm_ctrl.sv
// Controller state machine that sequences node replays and result emission.
`default_nettype none
module wtkm_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic [wtkm_pkg::KIND_W-1:0]   i_kind,
    input  wtkm_pkg::t_stat                    i_stat,
    output wtkm_pkg::t_cmd                     o_cmd,
    output logic                               o_busy
);
    import wtkm_pkg::*;

    t_state r_state, n_state;
    logic   r_up, n_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_up    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_up    <= n_up;
        end
    end

    always_comb begin
        n_state = r_state;
        n_up    = r_up;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_kind)
                        KIND_START: begin
                            n_state = ST_RD_A;
                            n_up    = 1'b0;
                        end
                        KIND_ADVANCE: begin
                            // Without a current winner the advance only reports done.
                            n_state = i_stat.root_ok ? ST_RD_A : ST_EMIT_RD;
                            n_up    = 1'b1;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD_A:    n_state = ST_RD_B;
            ST_RD_B:    n_state = ST_VAL_A;
            ST_VAL_A:   n_state = ST_VAL_B;
            ST_VAL_B:   n_state = ST_CMP;
            ST_CMP:     n_state = i_stat.node_root ? ST_EMIT_RD : ST_RD_A;
            ST_EMIT_RD: n_state = ST_EMIT;
            ST_EMIT:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_kind)
                        KIND_LOAD:    o_cmd.load     = 1'b1;
                        KIND_START:   o_cmd.bld_init = 1'b1;
                        KIND_ADVANCE: o_cmd.adv_upd  = i_stat.root_ok;
                        default:      o_cmd.load     = 1'b0;
                    endcase
                end
            end
            ST_RD_A:  o_cmd.rd_a = 1'b1;
            ST_RD_B:  o_cmd.rd_b = 1'b1;
            ST_VAL_A: o_cmd.val_a = 1'b1;
            ST_VAL_B: o_cmd.val_b = 1'b1;
            ST_CMP: begin
                o_cmd.cmp     = 1'b1;
                o_cmd.step_up = r_up;
            end
            ST_EMIT_RD: o_cmd.emit_rd = 1'b1;
            ST_EMIT:    o_cmd.emit    = 1'b1;
            default:    o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

// File: rtl/wtkm_dp.sv
// Datapath: leaf storage, tree node memory, shared comparator and result register.
`default_nettype none
module wtkm_dp #(
    parameter int NUM_STREAMS = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wtkm_pkg::t_cmd                            i_cmd,
    input  wire logic [wtkm_pkg::STREAM_W-1:0]        i_stream,
    input  wire logic signed [DATA_WIDTH-1:0]         i_value,
    input  wire logic                                 i_last_of_stream,
    output wtkm_pkg::t_stat                           o_stat,
    output logic                                      o_valid,
    output logic signed [DATA_WIDTH-1:0]              o_winner_value,
    output logic [wtkm_pkg::STREAM_W-1:0]             o_winner_stream,
    output logic                                      o_done_res
);
    import wtkm_pkg::*;

    localparam int LOG_P = $clog2(NUM_STREAMS);
    localparam int P     = 1 << LOG_P;
    localparam int IDW   = $clog2(NUM_STREAMS + 1);
    localparam logic [IDW-1:0] NONE_ID = IDW'(NUM_STREAMS);

    // Leaf flags; bits at or above NUM_STREAMS are never set.
    logic [P-1:0]                r_valid;
    logic [P-1:0]                r_last;
    logic [P-1:0]                r_nvalid;
    logic [LOG_P-1:0]            r_node;
    logic [IDW-1:0]              r_a;
    logic [IDW-1:0]              r_b;
    logic [IDW-1:0]              r_root;
    logic                        r_nv_q;
    logic signed [DATA_WIDTH-1:0] r_va;
    logic                        r_o_valid;
    logic signed [DATA_WIDTH-1:0] r_o_value;
    logic [STREAM_W-1:0]         r_o_stream;
    logic                        r_o_done;

    logic [LOG_P-1:0]            ld_addr;
    logic                        ld_ok;
    logic [LOG_P-1:0]            root_lp;
    logic                        root_ok;
    logic [LOG_P:0]              leaf_c;
    logic                        leaf_level;
    logic [LOG_P-1:0]            nram_raddr;
    logic [IDW-1:0]              nram_rdata;
    logic [IDW-1:0]              ch_raw;
    logic [IDW-1:0]              ch_id;
    logic                        vram_we;
    logic [LOG_P-1:0]            vram_waddr;
    logic [LOG_P-1:0]            vram_raddr;
    logic signed [DATA_WIDTH-1:0] vdata;
    logic                        take_b;
    logic [IDW-1:0]              win;

    function automatic logic id_ok(input logic [IDW-1:0] id, input logic [P-1:0] vld);
        return (32'(id) < NUM_STREAMS) && vld[id[LOG_P-1:0]];
    endfunction

    assign ld_addr    = LOG_P'(i_stream);
    assign ld_ok      = (32'(i_stream) < NUM_STREAMS);
    assign root_lp    = r_root[LOG_P-1:0];
    assign root_ok    = id_ok(r_root, r_valid);
    assign leaf_c     = {1'b1, root_lp};
    assign leaf_level = r_node[LOG_P-1];

    // Children of node i sit at 2i and 2i+1; the low bit picks child b.
    assign nram_raddr = LOG_P'({r_node, i_cmd.rd_b});

    // A child is a leaf on the lowest level, otherwise the winner stored for it.
    always_comb begin
        if (leaf_level) begin
            ch_raw = IDW'(LOG_P'({r_node, i_cmd.val_a}));
        end else begin
            ch_raw = r_nv_q ? nram_rdata : NONE_ID;
        end
        ch_id = id_ok(ch_raw, r_valid) ? ch_raw : NONE_ID;
    end

    assign vram_we    = (i_cmd.load && ld_ok) || (i_cmd.adv_upd && !r_last[root_lp]);
    assign vram_waddr = i_cmd.load ? ld_addr : root_lp;

    always_comb begin
        if (i_cmd.val_a) begin
            vram_raddr = r_a[LOG_P-1:0];
        end else if (i_cmd.val_b) begin
            vram_raddr = r_b[LOG_P-1:0];
        end else begin
            vram_raddr = root_lp;
        end
    end

    // An empty side always loses; on equal values the lower stream (side a) wins.
    assign take_b = (r_a == NONE_ID) || ((r_b != NONE_ID) && (vdata > r_va));
    assign win    = take_b ? r_b : r_a;

    wtkm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NUM_STREAMS)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_waddr (vram_waddr),
        .i_wdata (i_value),
        .i_raddr (vram_raddr),
        .o_rdata (vdata)
    );

    wtkm_ram #(
        .WIDTH (IDW),
        .DEPTH (P)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cmp),
        .i_waddr (r_node),
        .i_wdata (win),
        .i_raddr (nram_raddr),
        .o_rdata (nram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_last    <= '0;
            r_nvalid  <= '0;
            r_root    <= NONE_ID;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.emit;
            if (i_cmd.load && ld_ok) begin
                r_valid[ld_addr] <= 1'b1;
                r_last[ld_addr]  <= i_last_of_stream;
            end
            if (i_cmd.adv_upd) begin
                if (r_last[root_lp]) begin
                    r_valid[root_lp] <= 1'b0;
                end else begin
                    r_last[root_lp] <= i_last_of_stream;
                end
            end
            if (i_cmd.cmp) begin
                r_nvalid[r_node] <= 1'b1;
                if (r_node == LOG_P'(1)) begin
                    r_root <= win;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bld_init) begin
            r_node <= '1;
        end else if (i_cmd.adv_upd) begin
            r_node <= leaf_c[LOG_P:1];
        end else if (i_cmd.cmp) begin
            r_node <= i_cmd.step_up ? (r_node >> 1) : (r_node - 1'b1);
        end
        if (i_cmd.rd_a || i_cmd.rd_b) begin
            r_nv_q <= r_nvalid[nram_raddr];
        end
        if (i_cmd.rd_b) begin
            r_a <= ch_id;
        end
        if (i_cmd.val_a) begin
            r_b <= ch_id;
        end
        if (i_cmd.val_b) begin
            r_va <= vdata;
        end
        if (i_cmd.emit) begin
            r_o_value  <= root_ok ? vdata : '0;
            r_o_stream <= root_ok ? STREAM_W'(r_root) : '0;
            r_o_done   <= !root_ok;
        end
    end

    assign o_stat.root_ok   = root_ok;
    assign o_stat.node_root = (r_node == LOG_P'(1));
    assign o_valid          = r_o_valid;
    assign o_winner_value   = r_o_value;
    assign o_winner_stream  = r_o_stream;
    assign o_done_res       = r_o_done;

endmodule
`default_nettype wire

// File: rtl/winner_tree_kway_merge.sv
// Top level of the winner tree k-way merge: controller, datapath and checks.
//
// Commands enter on start/busy: a transaction is taken at a rising edge with start
// high and busy low, carrying i_kind, i_stream, i_value and i_last_of_stream.
// A load writes one stream head in the accepting cycle; busy stays low, so loads
// may follow back to back, and no result is produced.
// A start rebuilds every node of the tree, bottom up; an advance replaces the
// current winner's head (or retires that stream) and replays only its path.
// Each node is replayed on the single comparator in turn: two node memory reads,
// two leaf value memory reads, then compare and write back.
// With L tree levels (L = clog2(NUM_STREAMS)), a start replays all 2**L-1 nodes
// and an advance replays the L nodes on the path of the current winner;
// an advance with no current winner replays no node and only emits a done result.
// The result transaction shows on o_valid for one cycle right after busy falls,
// the same cycle in which the next command may already be taken.
// Results cannot be stalled. Reset empties all streams and the tree.
`default_nettype none
`include "winner_tree_kway_merge_assert.svh"
module winner_tree_kway_merge #(
    parameter int NUM_STREAMS = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [wtkm_pkg::KIND_W-1:0]      i_kind,
    input  wire logic [wtkm_pkg::STREAM_W-1:0]    i_stream,
    input  wire logic signed [DATA_WIDTH-1:0]     i_value,
    input  wire logic                             i_last_of_stream,
    output logic                                  o_valid,
    output logic signed [DATA_WIDTH-1:0]          o_winner_value,
    output logic [wtkm_pkg::STREAM_W-1:0]         o_winner_stream,
    output logic                                  o_done_res
);
    import wtkm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    wtkm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    wtkm_dp #(
        .NUM_STREAMS (NUM_STREAMS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_stream         (i_stream),
        .i_value          (i_value),
        .i_last_of_stream (i_last_of_stream),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .o_winner_value   (o_winner_value),
        .o_winner_stream  (o_winner_stream),
        .o_done_res       (o_done_res)
    );

    // A result only follows a command that kept the block busy.
    `WTKM_ASSERT_NOW(a_result_after_busy, i_clk, i_rst_n, o_valid, $past(busy))
    // A done result carries no winner.
    `WTKM_ASSERT_NOW(a_done_is_empty, i_clk, i_rst_n, o_valid && o_done_res, (o_winner_value == '0) && (o_winner_stream == '0))
    // Start and advance always occupy the sequencer.
    `WTKM_ASSERT_NEXT(a_cmd_goes_busy, i_clk, i_rst_n, start && !busy && (i_kind == KIND_START || i_kind == KIND_ADVANCE), busy)
    // A load completes in its accepting cycle and produces no result.
    `WTKM_ASSERT_NEXT(a_load_no_busy, i_clk, i_rst_n, start && !busy && (i_kind == KIND_LOAD), !busy && !o_valid)

endmodule
`default_nettype wire

// File: tb/winner_tree_kway_merge_checker.sv
// Checker that predicts the winner tree merge results and compares them with the block.
`timescale 1ns / 1ps
module winner_tree_kway_merge_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_busy,
    input  wire logic [wtkm_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [wtkm_pkg::STREAM_W-1:0] i_stream,
    input  wire logic signed [31:0]            i_value,
    input  wire logic                          i_last_of_stream,
    input  wire logic                          i_res_valid,
    input  wire logic signed [31:0]            i_res_value,
    input  wire logic [wtkm_pkg::STREAM_W-1:0] i_res_stream,
    input  wire logic                          i_res_done,
    output int                                 o_fail_count,
    output int                                 o_open_count
);
    import wtkm_pkg::*;

    localparam int         STREAMS   = 64;
    localparam logic [6:0] NO_STREAM = 7'd64;

    typedef struct {
        logic signed [31:0]   value;
        logic [STREAM_W-1:0]  stream;
        logic                 done;
    } t_merge_out;

    logic signed [31:0] head_value [STREAMS];
    logic               head_live  [STREAMS];
    logic               head_last  [STREAMS];
    logic [6:0]         node_win   [1:STREAMS-1];
    t_merge_out         merge_q    [$];
    int                 fail_total = 0;
    int                 open_total = 0;

    assign o_fail_count = fail_total;
    assign o_open_count = open_total;

    // Nodes at or above STREAMS are leaves; a stored node winner whose leaf has
    // dropped out counts as no winner at all.
    function automatic logic [6:0] subtree_winner(input int c);
        logic [6:0] s;
        if (c >= STREAMS) begin
            return head_live[c - STREAMS] ? 7'(c - STREAMS) : NO_STREAM;
        end
        s = node_win[c];
        if (s >= NO_STREAM || !head_live[s[5:0]]) return NO_STREAM;
        return s;
    endfunction

    function automatic void replay_node(input int n);
        logic [6:0] a;
        logic [6:0] b;
        a = subtree_winner(2 * n);
        b = subtree_winner(2 * n + 1);
        if (a == NO_STREAM) begin
            node_win[n] = b;
        end else if (b == NO_STREAM) begin
            node_win[n] = a;
        end else begin
            // The left child holds the lower streams, so it keeps ties.
            node_win[n] = (head_value[b[5:0]] > head_value[a[5:0]]) ? b : a;
        end
    endfunction

    function automatic t_merge_out root_result();
        t_merge_out r;
        logic [6:0] w;
        w = node_win[1];
        if (w >= NO_STREAM || !head_live[w[5:0]]) begin
            r.value  = '0;
            r.stream = '0;
            r.done   = 1'b1;
        end else begin
            r.value  = head_value[w[5:0]];
            r.stream = w[5:0];
            r.done   = 1'b0;
        end
        return r;
    endfunction

    task automatic apply_cmd();
        logic [6:0] w;
        case (i_kind)
            KIND_LOAD: begin
                head_value[i_stream] = i_value;
                head_last[i_stream]  = i_last_of_stream;
                head_live[i_stream]  = 1'b1;
            end
            KIND_START: begin
                for (int n = STREAMS - 1; n >= 1; n--) replay_node(n);
                merge_q.insert(merge_q.size(), root_result());
            end
            KIND_ADVANCE: begin
                w = node_win[1];
                if (w < NO_STREAM && head_live[w[5:0]]) begin
                    if (head_last[w[5:0]]) begin
                        head_live[w[5:0]] = 1'b0;
                    end else begin
                        head_value[w[5:0]] = i_value;
                        head_last[w[5:0]]  = i_last_of_stream;
                    end
                    for (int n = (STREAMS + int'(w)) >> 1; n >= 1; n >>= 1) replay_node(n);
                end
                merge_q.insert(merge_q.size(), root_result());
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_merge_out want;
        if (merge_q.size() == 0) begin
            $error("merge result with no command outstanding: value %0d stream %0d done %0b",
                   i_res_value, i_res_stream, i_res_done);
            fail_total++;
        end else begin
            want = merge_q.pop_front();
            if (i_res_value !== want.value) begin
                $error("winner_value: expected %0d, actual %0d", want.value, i_res_value);
                fail_total++;
            end
            if (i_res_stream !== want.stream) begin
                $error("winner_stream: expected %0d, actual %0d", want.stream, i_res_stream);
                fail_total++;
            end
            if (i_res_done !== want.done) begin
                $error("done_res: expected %0b, actual %0b", want.done, i_res_done);
                fail_total++;
            end
        end
    endtask

    // The result of an older transaction may show in the same cycle as a new
    // command is taken, so the result is checked before the command is applied.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STREAMS; k++) begin
                head_value[k] = '0;
                head_live[k]  = 1'b0;
                head_last[k]  = 1'b0;
            end
            for (int k = 1; k < STREAMS; k++) node_win[k] = NO_STREAM;
            merge_q.delete();
        end else begin
            if (i_res_valid) check_result();
            if (i_start && !i_busy) apply_cmd();
        end
        open_total <= merge_q.size();
    end

endmodule

// File: tb/winner_tree_kway_merge_tb.sv
// Testbench top: drives merge commands into the winner tree block and gives the verdict.
`timescale 1ns / 1ps
module winner_tree_kway_merge_tb;
    import wtkm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NOP     = 2'd3;
    localparam int                TARGET_CMDS  = 1650;
    localparam int                CALM_FROM    = 1400;
    localparam int                QUIET_LIMIT  = 5000;
    localparam int                DRAIN_CYCLES = 64;
    localparam logic signed [31:0] VAL_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN     = 32'sh8000_0000;

    logic                     i_clk            = 1'b0;
    logic                     i_rst_n          = 1'b0;
    logic                     start            = 1'b0;
    logic [KIND_W-1:0]        i_kind           = '0;
    logic [STREAM_W-1:0]      i_stream         = '0;
    logic signed [31:0]       i_value          = '0;
    logic                     i_last_of_stream = 1'b0;
    logic                     busy;
    logic                     o_valid;
    logic signed [31:0]       o_winner_value;
    logic [STREAM_W-1:0]      o_winner_stream;
    logic                     o_done_res;

    int fail_count;
    int open_count;
    int cmds_sent    = 0;
    int gap_pct      = 0;
    int quiet_cycles = 0;

    // Elements still to come for each stream after its current head.
    logic signed [31:0]  stream_rest [64][$];
    logic signed [31:0]  got_value;
    logic [STREAM_W-1:0] got_stream;
    logic                got_done;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    winner_tree_kway_merge i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_stream         (i_stream),
        .i_value          (i_value),
        .i_last_of_stream (i_last_of_stream),
        .o_valid          (o_valid),
        .o_winner_value   (o_winner_value),
        .o_winner_stream  (o_winner_stream),
        .o_done_res       (o_done_res)
    );

    winner_tree_kway_merge_checker merge_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_kind           (i_kind),
        .i_stream         (i_stream),
        .i_value          (i_value),
        .i_last_of_stream (i_last_of_stream),
        .i_res_valid      (o_valid),
        .i_res_value      (o_winner_value),
        .i_res_stream     (o_winner_stream),
        .i_res_done       (o_done_res),
        .o_fail_count     (fail_count),
        .o_open_count     (open_count)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2, 3: return 32'($urandom_range(0, 15)) - 32'd8;
            default: return 32'($urandom);
        endcase
    endfunction

    // Returns at the edge that takes the transaction.
    task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [STREAM_W-1:0] strm,
                            input logic signed [31:0] value, input logic last);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_kind           <= kind;
        i_stream         <= strm;
        i_value          <= value;
        i_last_of_stream <= last;
        do @(posedge i_clk); while (busy);
        if (kind != KIND_NOP) cmds_sent++;
    endtask

    task automatic await_result();
        start <= 1'b0;
        do @(posedge i_clk); while (!o_valid);
        got_value  = o_winner_value;
        got_stream = o_winner_stream;
        got_done   = o_done_res;
    endtask

    // One well-formed merge: load descending streams, build, then feed each
    // winner's next element until every stream has run dry.
    task automatic run_merge(input int n_streams);
        int                 order [64];
        int                 s;
        int                 tmp;
        int                 len;
        int                 guard;
        logic signed [31:0] v;
        longint             nxt;
        for (int j = 0; j < 64; j++) order[j] = j;
        for (int j = 63; j > 0; j--) begin
            s        = $urandom_range(0, j);
            tmp      = order[j];
            order[j] = order[s];
            order[s] = tmp;
        end
        for (int j = 0; j < n_streams; j++) begin
            s   = order[j];
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
            v   = pick_value();
            nxt = longint'(v);
            stream_rest[s].delete();
            repeat (len - 1) begin
                case ($urandom_range(0, 3))
                    0: ;
                    1: nxt = nxt - longint'($urandom_range(1, 20));
                    2: nxt = nxt - longint'($urandom);
                    default: nxt = nxt - longint'($urandom_range(1, 100000));
                endcase
                if (nxt < longint'(VAL_MIN)) nxt = longint'(VAL_MIN);
                stream_rest[s].insert(stream_rest[s].size(), 32'(nxt));
            end
            send_cmd(KIND_LOAD, 6'(s), v, stream_rest[s].size() == 0);
        end
        send_cmd(KIND_START, 6'($urandom), 32'($urandom), 1'($urandom));
        await_result();
        guard = 0;
        while (!got_done && guard < 2000) begin
            if ($urandom_range(0, 19) == 0) begin
                s = $urandom_range(0, 63);
                stream_rest[s].delete();
                send_cmd(KIND_LOAD, 6'(s), pick_value(), 1'($urandom));
            end
            s = got_stream;
            if (stream_rest[s].size() != 0) begin
                v = stream_rest[s].pop_front();
                send_cmd(KIND_ADVANCE, 6'($urandom), v, stream_rest[s].size() == 0);
            end else begin
                // Unknown continuation: mark it last so the stream retires next time.
                send_cmd(KIND_ADVANCE, 6'($urandom), 32'($urandom), 1'b1);
            end
            await_result();
            guard++;
        end
        if ($urandom_range(0, 4) == 0) begin
            send_cmd(KIND_ADVANCE, 6'($urandom), pick_value(), 1'($urandom));
        end
    endtask

    task automatic run_noise(input int count);
        logic [KIND_W-1:0]   kind;
        logic [STREAM_W-1:0] s;
        int                  roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)      kind = KIND_LOAD;
            else if (roll < 55) kind = KIND_START;
            else if (roll < 95) kind = KIND_ADVANCE;
            else                kind = KIND_NOP;
            s = 6'($urandom);
            if (kind == KIND_LOAD) stream_rest[s].delete();
            send_cmd(kind, s, pick_value(), 1'($urandom));
        end
    endtask

    initial begin
        int roll;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty tree, ignored kind, extremes, ties and a load after the build.
        send_cmd(KIND_ADVANCE, 6'd0, VAL_MAX, 1'b1);
        send_cmd(KIND_START, 6'd63, VAL_MIN, 1'b0);
        send_cmd(KIND_NOP, 6'd63, 32'hFFFF_FFFF, 1'b1);
        send_cmd(KIND_LOAD, 6'd0, VAL_MAX, 1'b0);
        send_cmd(KIND_LOAD, 6'd5, VAL_MAX, 1'b0);
        send_cmd(KIND_LOAD, 6'd63, VAL_MIN, 1'b1);
        send_cmd(KIND_LOAD, 6'd62, -32'sd1, 1'b0);
        send_cmd(KIND_START, 6'd0, 32'sd0, 1'b0);
        send_cmd(KIND_ADVANCE, 6'd0, VAL_MAX, 1'b0);
        send_cmd(KIND_ADVANCE, 6'd0, VAL_MIN, 1'b1);
        send_cmd(KIND_LOAD, 6'd1, 32'sh4000_0000, 1'b1);
        repeat (6) send_cmd(KIND_ADVANCE, 6'h2A, 32'sh5555_5555, 1'b1);
        send_cmd(KIND_LOAD, 6'd33, 32'sd0, 1'b0);
        send_cmd(KIND_LOAD, 6'd31, 32'sd0, 1'b1);
        send_cmd(KIND_START, 6'h15, 32'shAAAA_AAAA, 1'b1);
        send_cmd(KIND_NOP, 6'd0, 32'sd0, 1'b0);
        send_cmd(KIND_START, 6'd0, 32'sd0, 1'b0);
        repeat (3) send_cmd(KIND_ADVANCE, 6'd0, 32'sd0, 1'b0);
        await_result();

        while (cmds_sent < TARGET_CMDS) begin
            if (cmds_sent >= CALM_FROM) begin
                gap_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 15;
                    default: gap_pct = 40;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 6)       run_merge(64);
            else if (roll < 20) run_merge($urandom_range(9, 24));
            else if (roll < 75) run_merge($urandom_range(1, 8));
            else                run_noise($urandom_range(5, 30));
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && open_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
